// ===== src/fcb_pkg.sv =====
// shared types and constants for the circular-buffer fir filter
// no dependencies; imported by every module of the block
`default_nettype none

package fcb_pkg;

    // default tap count
    localparam int TAPS_DEFAULT = 11;

    // widths fixed by the interface
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int INDEX_W = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
    localparam logic [OP_W-1:0] OP_COEF   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;  // zero the accumulator
        logic valid;  // operands present this cycle
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== src/fcb_ram.sv =====
// single-write, single-read memory with registered read and per-entry valid bits
// entries that are not valid read as zero; depends on fcb_pkg
`default_nettype none

module fcb_ram
    import fcb_pkg::*;
#(
    parameter int DEPTH = TAPS_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [DEPTH-1:0]  vld_next;
    logic [DATA_W-1:0] rd_data_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (clear)
        begin
            vld_next = '0;
        end
        else if (wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= vld_reg[rd_addr] ? mem_reg[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/fcb_mac.sv =====
// shared multiply-accumulate unit: registered product, then wrapping accumulate
// depends on fcb_pkg for widths and the control struct
`default_nettype none

module fcb_mac
    import fcb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mac_ctrl_t         ctrl,
    input  wire logic [DATA_W-1:0] coef,
    input  wire logic [DATA_W-1:0] hist,
    output logic      [DATA_W-1:0] acc
);

    logic [2*DATA_W-1:0] full_prod;
    logic [DATA_W-1:0]   prod_reg;
    logic                prod_vld_reg;
    logic [DATA_W-1:0]   acc_reg;
    logic [DATA_W-1:0]   acc_next;

    assign full_prod = coef * hist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= full_prod[DATA_W-1:0];
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== src/fir_filter_circular_buffer.sv =====
// top level of the direct-form fir filter with a circular sample history
// uses fcb_pkg, fcb_ram (history and coefficient stores) and fcb_mac
//
// Each input transaction carries an operation. A filter transaction writes its
// sample into the circular history and returns one result, the sum over all
// taps of coefficient[j] times the sample j steps back, with products and sum
// wrapping to 32 bits. A coefficient transaction writes one coefficient (an
// index of TAPS or more is dropped), a clear transaction zeroes the history
// and rewinds the write slot; neither returns a result, and operation code 3
// does nothing. A filter transaction occupies the block from its acceptance in
// the idle state through a run state, in which the single shared multiplier
// takes one tap per cycle from the two single-port-read stores, a drain state
// that empties the read and product registers, and a finish state that loads
// the output register. If the previous result is still waiting in the output
// register, the block stays in the finish state until that result is taken,
// and the input stays stalled. Coefficient, clear and unused transactions
// complete when accepted. The output register holds a finished result while
// the next transaction is accepted. Both stores come out of reset as all zero
// through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module fir_filter_circular_buffer
    import fcb_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic        [OP_W-1:0]    operation,
    input  wire logic signed [DATA_W-1:0]  sample,
    input  wire logic        [INDEX_W-1:0] coef_index,
    input  wire logic signed [DATA_W-1:0]  coef_value,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed      [DATA_W-1:0]  filtered
);

    // address width of the stores and width for the coefficient index check,
    // one bit above the wider of the two so that TAPS itself fits
    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int IW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     slot_reg, slot_next;     // write slot of the next sample
    logic [AW-1:0]     tap_reg, tap_next;       // coefficient index j
    logic [AW-1:0]     pos_reg, pos_next;       // history position (slot + j) mod TAPS
    logic              drain_reg, drain_next;   // set once the read register has emptied
    logic              rd_vld_reg;              // store read data present
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] filtered_reg, filtered_next;

    logic              in_accept;
    logic              out_free;
    logic [IW-1:0]     idx_ext;
    logic              coef_ok;
    logic              hist_wr, hist_clear, coef_wr, rd_en;
    logic [DATA_W-1:0] coef_rd, hist_rd, acc;
    mac_ctrl_t         mac_ctrl;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // coefficient index range check at the wider of the two widths
    assign idx_ext = IW'(coef_index);
    assign coef_ok = (idx_ext < IW'(TAPS));

    assign hist_wr    = in_accept && (operation == OP_FILTER);
    assign hist_clear = in_accept && (operation == OP_CLEAR);
    assign coef_wr    = in_accept && (operation == OP_COEF) && coef_ok;
    assign rd_en      = (state_reg == ST_RUN);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        tap_next       = tap_reg;
        pos_next       = pos_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg;
        filtered_next  = filtered_reg;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.valid = rd_vld_reg;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (operation)
                        OP_FILTER:
                        begin
                            // walk taps starting at the slot just written
                            tap_next       = '0;
                            pos_next       = slot_reg;
                            slot_next      = (slot_reg == '0) ? LAST : slot_reg - 1'b1;
                            mac_ctrl.clear = 1'b1;
                            state_next     = ST_RUN;
                        end
                        OP_CLEAR:
                        begin
                            slot_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // one tap issued to the stores this cycle
                pos_next = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
                tap_next = tap_reg + 1'b1;
                if (tap_reg == LAST)
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // read register, then product register, empty into the accumulator
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    filtered_next  = acc;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            tap_reg       <= '0;
            pos_reg       <= '0;
            drain_reg     <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            tap_reg       <= tap_next;
            pos_reg       <= pos_next;
            drain_reg     <= drain_next;
            rd_vld_reg    <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        filtered_reg <= filtered_next;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // circular sample history
    fcb_ram #(
        .DEPTH (TAPS),
        .AW    (AW)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (hist_clear),
        .wr_en   (hist_wr),
        .wr_addr (slot_reg),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (pos_reg),
        .rd_data (hist_rd)
    );

    // coefficient store, never cleared after reset
    fcb_ram #(
        .DEPTH (TAPS),
        .AW    (AW)
    ) u_coef (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (1'b0),
        .wr_en   (coef_wr),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data (coef_value),
        .rd_en   (rd_en),
        .rd_addr (tap_reg),
        .rd_data (coef_rd)
    );

    // shared multiply-accumulate
    fcb_mac u_mac (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (mac_ctrl),
        .coef (coef_rd),
        .hist (hist_rd),
        .acc  (acc)
    );

    // a filter transaction always starts the tap walk
    a_filter_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && operation == OP_FILTER) |=> (state_reg == ST_RUN && tap_reg == '0))
        else $error("filter transaction did not start the tap walk");

    // the walk ends after the last tap
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && tap_reg == LAST) |=> (state_reg == ST_DRAIN))
        else $error("tap walk did not end at the last tap");

    // operands reach the multiplier only during the walk or its drain
    a_mac_window: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("multiplier fed outside a filter transaction");

    // a finished result is presented once the output register is free
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (out_valid && state_reg == ST_IDLE))
        else $error("finished result not presented");

endmodule

`default_nettype wire
